[hw/rtl/crcc_pkg.sv]
package crcc_pkg;

    // Table and count geometry
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd4;
    localparam logic [CNT_W-1:0] CNT_MAX   = 7'd64;
    localparam logic [CNT_W-1:0] CNT_MIN   = 7'd1;

    // Fixed-point formats: parameter Q0.16, weights doubled signed Q4.16
    localparam int FRAC_BITS = 16;
    localparam int W_W       = 20;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = W_W + COORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int TAPS      = 4;
    localparam int AXES      = 3;

    // Request type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One control point, element 0 is x, 1 is y, 2 is z
    typedef t_coord [AXES-1:0] t_point;

    typedef struct packed {
        logic                 req_type;
        logic [IDX_W-1:0]     point_index;
        t_coord               point_x;
        t_coord               point_y;
        t_coord               point_z;
        logic [FRAC_BITS-1:0] curve_param;
    } t_req;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
    } t_res;

endpackage

[hw/rtl/catmull_rom_closed_curve_eval.sv]
// Closed uniform Catmull-Rom curve evaluator. Write words store one control
// point (x, y, z in Q16.16) into a slot below the point count; evaluate words
// carry t in Q0.16 and give one position word, Q16.16 saturated. One word is
// taken every cycle: busy is never asserted and a write is seen by every
// evaluate word started after it. The pipeline has eight register stages: t
// times n, point table read alongside u^2, u^3, basis weights, the 20x32
// products, two adder levels, and rounding with saturation. There is no output
// backpressure; o_strobe marks each result for one cycle. The user must write
// the point count through the cfg port (always ready) only while no evaluation
// is in flight; the block itself does not enforce this. Zero counts as one
// point and counts above 64 as 64. Reading a slot never written since reset
// gives an undefined position.
module catmull_rom_closed_curve_eval (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  crcc_pkg::t_req             i_req,
    output logic                       o_strobe,
    output crcc_pkg::t_res             o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [crcc_pkg::CNT_W-1:0] i_cfg_data
);

    // Saturate a rounded sum to 32 bits; v already holds S + 2^16
    function automatic crcc_pkg::t_coord sat_round(logic signed [crcc_pkg::SUM_W-1:0] v);
        logic signed [crcc_pkg::SUM_W-18:0] sh;
        crcc_pkg::t_coord                   res;
        sh = v[crcc_pkg::SUM_W-1:17];
        if (sh[crcc_pkg::SUM_W-18:31] == {(crcc_pkg::SUM_W-48){1'b0}} ||
            sh[crcc_pkg::SUM_W-18:31] == {(crcc_pkg::SUM_W-48){1'b1}}) begin
            res = sh[31:0];
        end else if (sh[crcc_pkg::SUM_W-18]) begin
            res = {1'b1, {31{1'b0}}};
        end else begin
            res = {1'b0, {31{1'b1}}};
        end
        return res;
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Point count, stored already clamped to 1..64
    logic [crcc_pkg::CNT_W-1:0] r_count;
    logic [crcc_pkg::CNT_W-1:0] n_count;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_count = crcc_pkg::CNT_MIN;
        end else if (i_cfg_data > crcc_pkg::CNT_MAX) begin
            n_count = crcc_pkg::CNT_MAX;
        end else begin
            n_count = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= crcc_pkg::CNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= n_count;
        end
    end

    // Stage 1: t * n, split into segment and fraction
    logic [crcc_pkg::FRAC_BITS+crcc_pkg::CNT_W-1:0] n_prod_tn;
    logic                                 r1_valid;
    logic                                 r1_eval;
    logic [crcc_pkg::IDX_W-1:0]           r1_seg;
    logic [crcc_pkg::FRAC_BITS-1:0]       r1_u;
    logic [crcc_pkg::IDX_W-1:0]           r1_index;
    crcc_pkg::t_point                     r1_point;

    assign n_prod_tn = i_req.curve_param * r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_eval     <= (i_req.req_type == crcc_pkg::REQ_EVAL);
        r1_seg      <= n_prod_tn[crcc_pkg::FRAC_BITS +: crcc_pkg::IDX_W];
        r1_u        <= n_prod_tn[crcc_pkg::FRAC_BITS-1:0];
        r1_index    <= i_req.point_index;
        r1_point[0] <= i_req.point_x;
        r1_point[1] <= i_req.point_y;
        r1_point[2] <= i_req.point_z;
    end

    // Neighbor slots with wraparound; writes land in the same stage as reads
    logic [crcc_pkg::CNT_W-1:0]                            n_seg_ext;
    logic [crcc_pkg::CNT_W-1:0]                            n_idx0;
    logic [crcc_pkg::CNT_W-1:0]                            n_idx2;
    logic [crcc_pkg::CNT_W-1:0]                            n_idx3;
    logic [crcc_pkg::TAPS-1:0][crcc_pkg::IDX_W-1:0]        n_raddr;
    logic                                                  n_we;
    crcc_pkg::t_point [crcc_pkg::TAPS-1:0]                 ram_rdata;

    always_comb begin
        n_seg_ext = {1'b0, r1_seg};
        n_idx0    = (r1_seg == '0) ? (r_count - 7'd1) : (n_seg_ext - 7'd1);
        n_idx2    = ((n_seg_ext + 7'd1) == r_count) ? '0 : (n_seg_ext + 7'd1);
        n_idx3    = ((n_idx2 + 7'd1) == r_count) ? '0 : (n_idx2 + 7'd1);
        n_raddr[0] = n_idx0[crcc_pkg::IDX_W-1:0];
        n_raddr[1] = r1_seg;
        n_raddr[2] = n_idx2[crcc_pkg::IDX_W-1:0];
        n_raddr[3] = n_idx3[crcc_pkg::IDX_W-1:0];
        n_we = r1_valid && !r1_eval && ({1'b0, r1_index} < r_count);
    end

    crcc_point_store u_store (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r1_index),
        .i_wdata (r1_point),
        .i_raddr (n_raddr),
        .o_rdata (ram_rdata)
    );

    // Stage 2: u^2
    logic [2*crcc_pkg::FRAC_BITS-1:0] n_uu;
    logic                             r2_valid;
    logic [crcc_pkg::FRAC_BITS-1:0]   r2_u;
    logic [crcc_pkg::FRAC_BITS-1:0]   r2_u2;

    assign n_uu = r1_u * r1_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid && r1_eval;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_u  <= r1_u;
        r2_u2 <= n_uu[2*crcc_pkg::FRAC_BITS-1:crcc_pkg::FRAC_BITS];
    end

    // Stage 3: u^3, table words captured
    logic [2*crcc_pkg::FRAC_BITS-1:0]      n_uuu;
    logic                                  r3_valid;
    logic [crcc_pkg::FRAC_BITS-1:0]        r3_u;
    logic [crcc_pkg::FRAC_BITS-1:0]        r3_u2;
    logic [crcc_pkg::FRAC_BITS-1:0]        r3_u3;
    crcc_pkg::t_point [crcc_pkg::TAPS-1:0] r3_pts;

    assign n_uuu = r2_u2 * r2_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_u   <= r2_u;
        r3_u2  <= r2_u2;
        r3_u3  <= n_uuu[2*crcc_pkg::FRAC_BITS-1:crcc_pkg::FRAC_BITS];
        r3_pts <= ram_rdata;
    end

    // Stage 4: doubled basis weights
    logic signed [crcc_pkg::W_W-1:0]       n_su;
    logic signed [crcc_pkg::W_W-1:0]       n_su2;
    logic signed [crcc_pkg::W_W-1:0]       n_su3;
    logic signed [crcc_pkg::W_W-1:0]       n_w [crcc_pkg::TAPS];
    logic                                  r4_valid;
    logic signed [crcc_pkg::W_W-1:0]       r4_w [crcc_pkg::TAPS];
    crcc_pkg::t_point [crcc_pkg::TAPS-1:0] r4_pts;

    always_comb begin
        n_su   = {{(crcc_pkg::W_W-crcc_pkg::FRAC_BITS){1'b0}}, r3_u};
        n_su2  = {{(crcc_pkg::W_W-crcc_pkg::FRAC_BITS){1'b0}}, r3_u2};
        n_su3  = {{(crcc_pkg::W_W-crcc_pkg::FRAC_BITS){1'b0}}, r3_u3};
        n_w[0] = (n_su2 <<< 1) - n_su3 - n_su;
        n_w[1] = (n_su3 <<< 1) + n_su3 - (n_su2 <<< 2) - n_su2
               + 20'sd131072;
        n_w[2] = (n_su2 <<< 2) + n_su - (n_su3 <<< 1) - n_su3;
        n_w[3] = n_su3 - n_su2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_w   <= n_w;
        r4_pts <= r3_pts;
    end

    // Stage 5: weight times coordinate, one multiplier per tap and axis
    logic                               r5_valid;
    logic signed [crcc_pkg::PROD_W-1:0] r5_prod [crcc_pkg::AXES][crcc_pkg::TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < crcc_pkg::AXES; j++) begin
            for (int k = 0; k < crcc_pkg::TAPS; k++) begin
                r5_prod[j][k] <= r4_w[k] * r4_pts[k][j];
            end
        end
    end

    // Stage 6: pair sums
    logic                               r6_valid;
    logic signed [crcc_pkg::PAIR_W-1:0] r6_pair [crcc_pkg::AXES][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < crcc_pkg::AXES; j++) begin
            r6_pair[j][0] <= crcc_pkg::PAIR_W'(r5_prod[j][0])
                           + crcc_pkg::PAIR_W'(r5_prod[j][1]);
            r6_pair[j][1] <= crcc_pkg::PAIR_W'(r5_prod[j][2])
                           + crcc_pkg::PAIR_W'(r5_prod[j][3]);
        end
    end

    // Stage 7: full sum plus half an output step for round half up
    logic                              r7_valid;
    logic signed [crcc_pkg::SUM_W-1:0] r7_sum [crcc_pkg::AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < crcc_pkg::AXES; j++) begin
            r7_sum[j] <= crcc_pkg::SUM_W'(r6_pair[j][0]) + crcc_pkg::SUM_W'(r6_pair[j][1])
                       + (crcc_pkg::SUM_W'(1) <<< crcc_pkg::FRAC_BITS);
        end
    end

    // Output register: shift down and saturate
    logic           r_out_valid;
    crcc_pkg::t_res r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res.pos_x <= sat_round(r7_sum[0]);
        r_out_res.pos_y <= sat_round(r7_sum[1]);
        r_out_res.pos_z <= sat_round(r7_sum[2]);
    end

    assign o_strobe = r_out_valid;
    assign o_res    = r_out_res;

endmodule

[hw/rtl/crcc_point_store.sv]
// Control point table, one copy per curve tap so that all four neighbors
// are read in the same cycle. Every copy takes the same write.
module crcc_point_store (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [crcc_pkg::IDX_W-1:0]            i_waddr,
    input  crcc_pkg::t_point                      i_wdata,
    input  logic [crcc_pkg::TAPS-1:0][crcc_pkg::IDX_W-1:0] i_raddr,
    output crcc_pkg::t_point [crcc_pkg::TAPS-1:0] o_rdata
);

    for (genvar b = 0; b < crcc_pkg::TAPS; b++) begin : g_bank
        crcc_pkg::t_point r_mem [crcc_pkg::MAX_POINTS];
        crcc_pkg::t_point r_rdata;

        // write port
        always_ff @(posedge i_clk) begin
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
        end

        // registered read port
        always_ff @(posedge i_clk) begin
            r_rdata <= r_mem[i_raddr[b]];
        end

        assign o_rdata[b] = r_rdata;
    end

endmodule

[hw/rtl/crcc_checker.sv]
// Port-level checks for the curve evaluator
module crcc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input crcc_pkg::t_req             i_req,
    input logic                       o_strobe,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready
);

    logic eval_accept;
    logic write_accept;

    assign eval_accept  = start && !busy && (i_req.req_type == crcc_pkg::REQ_EVAL);
    assign write_accept = start && !busy && (i_req.req_type == crcc_pkg::REQ_WRITE);

    // every evaluate word gives a result
    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_accept |-> ##8 o_strobe)
        else $error("evaluate word produced no result");

    // no result without an earlier evaluate word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(eval_accept && i_rst_n, 8))
        else $error("result without matching evaluate word");

    // write words never produce a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        write_accept |-> ##8 !o_strobe)
        else $error("write word produced a result");

    // the block never holds off requests or count writes
    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start || i_cfg_valid) |-> (!busy && o_cfg_ready))
        else $error("request or count write held off");

endmodule

bind catmull_rom_closed_curve_eval crcc_checker u_crcc_checker (.*);
